// ===== design/primality_test_trial_division_unit_assert.svh =====
// Assertion macros shared by the primality tester RTL.
`ifndef PRIMALITY_TEST_TRIAL_DIVISION_UNIT_ASSERT_SVH
`define PRIMALITY_TEST_TRIAL_DIVISION_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PTD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PTD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/ptd_pkg.sv =====
// Package with widths and sequencer states of the primality tester.
package ptd_pkg;

    localparam int NUM_W    = 32;
    localparam int MAG_W    = NUM_W - 1;
    localparam int CAND_W   = 17;
    localparam int SQ_W     = 2 * CAND_W;
    localparam int CNT_W    = $clog2(MAG_W);

    // First trial divisor; 3 is tried first and 6k-1 / 6k+1 candidates follow.
    localparam logic [CAND_W-1:0] FIRST_DIV    = CAND_W'(3);
    localparam logic [SQ_W-1:0]   FIRST_DIV_SQ = SQ_W'(9);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_DONE
    } t_state;

endpackage

// ===== design/primality_test_trial_division_unit.sv =====
// Primality tester: one signed 32-bit input, trial division by 3 and 6k+-1.
// Values settled at once (<= 1, 2, 3, even) go from the input transfer straight to the result;
// otherwise each trial divisor takes a square check plus 31 divider steps, and a final
// check ends the search when no divisor hits.
// One item in flight; a new transfer is taken the cycle after the result transfer.
// Synchronous active-low reset returns the sequencer to idle with no result held.
`include "primality_test_trial_division_unit_assert.svh"

module primality_test_trial_division_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic signed [ptd_pkg::NUM_W-1:0] i_number,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_is_prime
);
    import ptd_pkg::*;

    t_state              r_state, n_state;
    logic [MAG_W-1:0]    r_mag, n_mag;
    logic [MAG_W-1:0]    r_shift, n_shift;
    logic [CAND_W-1:0]   r_cand, n_cand;
    logic [SQ_W-1:0]     r_sq, n_sq;
    logic                r_step4, n_step4;
    logic [CAND_W-1:0]   r_rem, n_rem;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic                r_is_prime, n_is_prime;

    logic                in_xfer;
    logic                out_xfer;
    logic [CAND_W:0]     rem_sh;
    logic                rem_ge;
    logic [CAND_W-1:0]   rem_new;
    logic                div_last;
    logic                sq_over;
    logic [SQ_W-1:0]     cand_ext;
    logic                in_search;

    assign in_xfer  = i_in_valid && o_in_ready;
    assign out_xfer = o_out_valid && i_out_ready;

    // One restoring division step: bring in the next dividend bit, subtract if it fits.
    assign rem_sh   = {r_rem, r_shift[MAG_W-1]};
    assign rem_ge   = rem_sh >= {1'b0, r_cand};
    assign rem_new  = rem_ge ? CAND_W'(rem_sh - {1'b0, r_cand}) : rem_sh[CAND_W-1:0];
    assign div_last = r_cnt == CNT_W'(MAG_W - 1);

    // Search ends once the candidate's square exceeds the value.
    assign sq_over  = r_sq > SQ_W'(r_mag);
    assign cand_ext = SQ_W'(r_cand);

    // The sequencer is working on a candidate divisor.
    assign in_search = (r_state == ST_CHECK) || (r_state == ST_DIV);

    // Datapath next values.
    always_comb begin
        n_mag      = r_mag;
        n_shift    = r_shift;
        n_cand     = r_cand;
        n_sq       = r_sq;
        n_step4    = r_step4;
        n_rem      = r_rem;
        n_cnt      = r_cnt;
        n_is_prime = r_is_prime;
        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_mag   = i_number[MAG_W-1:0];
                    n_cand  = FIRST_DIV;
                    n_sq    = FIRST_DIV_SQ;
                    n_step4 = 1'b0;
                    if (i_number <= 1) begin
                        n_is_prime = 1'b0;
                    end else if (i_number == 2 || i_number == 3) begin
                        n_is_prime = 1'b1;
                    end else begin
                        // Odd values survive to the search; even ones are composite.
                        n_is_prime = i_number[0];
                    end
                end
            end
            ST_CHECK: begin
                n_shift = r_mag;
                n_rem   = '0;
                n_cnt   = '0;
                if (sq_over) begin
                    n_is_prime = 1'b1;
                end
            end
            ST_DIV: begin
                n_shift = {r_shift[MAG_W-2:0], 1'b0};
                n_rem   = rem_new;
                n_cnt   = r_cnt + CNT_W'(1);
                if (div_last) begin
                    if (rem_new == '0) begin
                        n_is_prime = 1'b0;
                    end
                    // Advance to the next candidate and update its square incrementally.
                    if (r_step4) begin
                        n_cand = r_cand + CAND_W'(4);
                        n_sq   = r_sq + (cand_ext << 3) + SQ_W'(16);
                    end else begin
                        n_cand = r_cand + CAND_W'(2);
                        n_sq   = r_sq + (cand_ext << 2) + SQ_W'(4);
                    end
                    n_step4 = (r_cand == FIRST_DIV) ? 1'b0 : ~r_step4;
                end
            end
            ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    if (i_number > 3 && i_number[0]) begin
                        n_state = ST_CHECK;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_CHECK: begin
                n_state = sq_over ? ST_DONE : ST_DIV;
            end
            ST_DIV: begin
                if (div_last) begin
                    n_state = (rem_new == '0) ? ST_DONE : ST_CHECK;
                end
            end
            ST_DONE: begin
                if (out_xfer) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Handshake outputs.
    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
            end
            ST_DONE: begin
                o_out_valid = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_is_prime = r_is_prime;

    // Control state is reset; the datapath registers are not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag      <= n_mag;
        r_shift    <= n_shift;
        r_cand     <= n_cand;
        r_sq       <= n_sq;
        r_step4    <= n_step4;
        r_rem      <= n_rem;
        r_cnt      <= n_cnt;
        r_is_prime <= n_is_prime;
    end

    // The partial remainder always stays below the divisor.
    `PTD_ASSERT_NOW(a_rem_below_div, i_clk, i_rst_n, r_state == ST_DIV, r_rem < r_cand, "remainder too big")

    // The incremental square tracks the candidate exactly.
    `PTD_ASSERT_NOW(a_sq_tracks, i_clk, i_rst_n, in_search, r_sq == cand_ext * cand_ext, "square off")

    // Trial divisors are always odd.
    `PTD_ASSERT_NOW(a_cand_odd, i_clk, i_rst_n, in_search, r_cand[0], "even trial divisor")

    // An accepted item never coexists with a pending result.
    `PTD_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, in_xfer, !o_in_ready, "input accepted while busy")

endmodule
